// ----- hdl/region_table_insert_merge_defines.svh -----
// Assertion macros shared by the region table RTL.
`ifndef REGION_TABLE_INSERT_MERGE_DEFINES_SVH
`define REGION_TABLE_INSERT_MERGE_DEFINES_SVH
// same-cycle implication, reset gated
`define RTIM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtim assertion failed");
// next-cycle implication, reset gated
`define RTIM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtim assertion failed");
`endif

// ----- hdl/rtim_pkg.sv -----
// Shared constants and types for the region table.
`timescale 1ns / 1ps
package rtim_pkg;
    localparam int REGION_SLOTS_DEF = 16;
    localparam int ADDRESS_BITS_DEF = 48;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_BITS = $clog2(PAGE_BYTES);
    localparam int STACK_TOP_BITS = 48;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_STACK  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_OVERLAP   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic overlap;
        logic left;
        logic right;
    } match_t;
endpackage

// ----- hdl/rtim_mem.sv -----
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
module rtim_mem #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- hdl/rtim_cmp.sv -----
// Compares one stored slot against the region being inserted.
`timescale 1ns / 1ps
module rtim_cmp
    import rtim_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic [ADDRESS_BITS-1:0] slot_start,
    input  logic [ADDRESS_BITS-1:0] slot_end,
    input  logic [ADDRESS_BITS-1:0] slot_source,
    input  logic [2:0]              slot_flags,
    input  logic                    slot_kind,
    input  logic [ADDRESS_BITS-1:0] new_start,
    input  logic [ADDRESS_BITS-1:0] new_end,
    input  logic [ADDRESS_BITS-1:0] new_source,
    input  logic [ADDRESS_BITS-1:0] new_source_end,
    input  logic [2:0]              new_flags,
    input  logic                    new_kind,
    output match_t                  match
);
    logic attr_eq;
    logic [ADDRESS_BITS-1:0] lhs;
    logic [ADDRESS_BITS-1:0] rhs;

    // slot.source + (slot.end - slot.start) == src, rearranged to two parallel adds
    assign lhs = slot_source + slot_end;
    assign rhs = new_source + slot_start;
    assign attr_eq = (slot_flags == new_flags) && (slot_kind == new_kind);

    assign match.overlap = ((slot_start <= new_start) && (new_start < slot_end)) ||
                           ((new_start <= slot_start) && (slot_start < new_end));
    assign match.left  = attr_eq && (slot_end == new_start) && (lhs == rhs);
    assign match.right = attr_eq && (slot_start == new_end) &&
                         (slot_source == new_source_end);
endmodule

// ----- hdl/region_table_insert_merge.sv -----
// Region table with insert, coalesce and clear; top level.
// Latency: clear, unused codes and malformed inserts answer on the cycle after start.
// A valid insert scans every slot, one entry per cycle through the read port of the
// slot memory, then raises the done strobe from the write state.
// One command at a time; the next start is taken once busy drops.
// Reset (async, active low) empties the table and zeroes the stack top.
`timescale 1ns / 1ps
`include "region_table_insert_merge_defines.svh"
module region_table_insert_merge
    import rtim_pkg::*;
#(
    parameter int REGION_SLOTS = REGION_SLOTS_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        command,
    input  logic [ADDRESS_BITS-1:0]           region_start,
    input  logic [ADDRESS_BITS-1:0]           region_end,
    input  logic [ADDRESS_BITS-1:0]           source_address,
    input  logic [2:0]                        access_flags,
    input  logic [1:0]                        region_kind,
    output logic                              done,
    output logic [1:0]                        status,
    output logic                              merged,
    output logic [$clog2(REGION_SLOTS+1)-1:0] region_count,
    output logic [STACK_TOP_BITS-1:0]         stack_top
);
    localparam int IW = $clog2(REGION_SLOTS);
    localparam int CW = $clog2(REGION_SLOTS + 1);
    localparam int AB = ADDRESS_BITS;
    // entry layout: {start, end, source, flags, kind}
    localparam int EW = 3 * AB + 4;
    localparam logic [IW-1:0] LAST = IW'(REGION_SLOTS - 1);

    typedef enum logic [1:0] {IDLE, SCAN, WRITE} state_t;

    state_t state_reg;
    logic [REGION_SLOTS-1:0] valid_reg;
    logic [CW-1:0] count_reg;
    logic [STACK_TOP_BITS-1:0] stack_reg;

    // transaction being worked on
    logic [AB-1:0] s_reg, e_reg, src_reg, src_end_reg;
    logic [2:0] fl_reg;
    logic kind_reg;
    logic stack_cmd_reg;

    // scan pipeline
    logic [IW-1:0] scan_idx_reg;
    logic issue_done_reg;
    logic p_valid_reg;
    logic [IW-1:0] p_idx_reg;

    // scan results
    logic ovl_reg, left_reg, right_reg, free_reg;
    logic [IW-1:0] left_idx_reg, right_idx_reg, free_idx_reg;
    logic [AB-1:0] l_start_reg, l_src_reg, r_end_reg;

    // result register
    logic done_reg;
    status_t status_reg;
    logic merged_reg;

    logic rd_en;
    logic [EW-1:0] rd_data;
    logic wr_en;
    logic [IW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [AB-1:0] r_start, r_end_d, r_src;
    match_t match;
    logic slot_live;
    logic malformed;
    logic [63:0] e_wide;

    assign r_start = rd_data[EW-1 -: AB];
    assign r_end_d = rd_data[EW-AB-1 -: AB];
    assign r_src   = rd_data[EW-2*AB-1 -: AB];

    assign rd_en = (state_reg == SCAN) && !issue_done_reg;

    rtim_mem #(.WIDTH(EW), .DEPTH(REGION_SLOTS)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rtim_cmp #(.ADDRESS_BITS(AB)) u_cmp (
        .slot_start     (r_start),
        .slot_end       (r_end_d),
        .slot_source    (r_src),
        .slot_flags     (rd_data[3:1]),
        .slot_kind      (rd_data[0]),
        .new_start      (s_reg),
        .new_end        (e_reg),
        .new_source     (src_reg),
        .new_source_end (src_end_reg),
        .new_flags      (fl_reg),
        .new_kind       (kind_reg),
        .match          (match)
    );

    assign slot_live = p_valid_reg && valid_reg[p_idx_reg];

    // 4 KiB alignment, ordering, flag and kind checks
    assign malformed = (region_start[PAGE_BITS-1:0] != '0) ||
                       (region_end[PAGE_BITS-1:0] != '0) ||
                       (source_address[PAGE_BITS-1:0] != '0) ||
                       !(region_start < region_end) ||
                       (access_flags == 3'd0) ||
                       (access_flags[1] && access_flags[2]) ||
                       region_kind[1];

    assign e_wide = 64'(e_reg);

    // write port: merges rewrite a neighbor, otherwise the new region takes the free slot
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = free_idx_reg;
        wr_data = {s_reg, e_reg, src_reg, fl_reg, kind_reg};
        if (state_reg == WRITE && !ovl_reg)
        begin
            if (left_reg && right_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = left_idx_reg;
                wr_data = {l_start_reg, r_end_reg, l_src_reg, fl_reg, kind_reg};
            end
            else if (left_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = left_idx_reg;
                wr_data = {l_start_reg, e_reg, l_src_reg, fl_reg, kind_reg};
            end
            else if (right_reg)
            begin
                wr_en   = 1'b1;
                wr_addr = right_idx_reg;
                wr_data = {s_reg, r_end_reg, src_reg, fl_reg, kind_reg};
            end
            else
            begin
                wr_en = free_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            stack_reg      <= '0;
            done_reg       <= 1'b0;
            status_reg     <= ST_OK;
            merged_reg     <= 1'b0;
            issue_done_reg <= 1'b0;
            p_valid_reg    <= 1'b0;
            scan_idx_reg   <= '0;
            ovl_reg        <= 1'b0;
            left_reg       <= 1'b0;
            right_reg      <= 1'b0;
            free_reg       <= 1'b0;
        end
        else
        begin
            done_reg    <= 1'b0;
            p_valid_reg <= rd_en;
            p_idx_reg   <= scan_idx_reg;
            unique case (state_reg)
                IDLE:
                begin
                    if (start)
                    begin
                        s_reg          <= region_start;
                        e_reg          <= region_end;
                        src_reg        <= source_address;
                        src_end_reg    <= source_address + (region_end - region_start);
                        fl_reg         <= access_flags;
                        kind_reg       <= region_kind[0];
                        stack_cmd_reg  <= (command == CMD_STACK);
                        scan_idx_reg   <= '0;
                        issue_done_reg <= 1'b0;
                        ovl_reg        <= 1'b0;
                        left_reg       <= 1'b0;
                        right_reg      <= 1'b0;
                        free_reg       <= 1'b0;
                        merged_reg     <= 1'b0;
                        unique case (command) inside
                            CMD_INSERT, CMD_STACK:
                            begin
                                if (malformed)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= ST_MALFORMED;
                                end
                                else
                                begin
                                    state_reg <= SCAN;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                valid_reg  <= '0;
                                count_reg  <= '0;
                                done_reg   <= 1'b1;
                                status_reg <= ST_OK;
                            end
                            default:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= ST_MALFORMED;
                            end
                        endcase
                    end
                end
                SCAN:
                begin
                    if (rd_en)
                    begin
                        if (scan_idx_reg == LAST)
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            scan_idx_reg <= scan_idx_reg + 1'b1;
                        end
                    end
                    if (p_valid_reg)
                    begin
                        if (!valid_reg[p_idx_reg] && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= p_idx_reg;
                        end
                        if (slot_live && match.overlap)
                        begin
                            ovl_reg <= 1'b1;
                        end
                        if (slot_live && match.left)
                        begin
                            left_reg     <= 1'b1;
                            left_idx_reg <= p_idx_reg;
                            l_start_reg  <= r_start;
                            l_src_reg    <= r_src;
                        end
                        if (slot_live && match.right)
                        begin
                            right_reg     <= 1'b1;
                            right_idx_reg <= p_idx_reg;
                            r_end_reg     <= r_end_d;
                        end
                        if (p_idx_reg == LAST)
                        begin
                            state_reg <= WRITE;
                        end
                    end
                end
                WRITE:
                begin
                    state_reg  <= IDLE;
                    done_reg   <= 1'b1;
                    merged_reg <= 1'b0;
                    if (ovl_reg)
                    begin
                        status_reg <= ST_OVERLAP;
                    end
                    else if (!left_reg && !right_reg && !free_reg)
                    begin
                        status_reg <= ST_FULL;
                    end
                    else
                    begin
                        status_reg <= ST_OK;
                        merged_reg <= left_reg || right_reg;
                        if (stack_cmd_reg)
                        begin
                            stack_reg <= e_wide[STACK_TOP_BITS-1:0];
                        end
                        if (left_reg && right_reg)
                        begin
                            valid_reg[right_idx_reg] <= 1'b0;
                            count_reg <= count_reg - 1'b1;
                        end
                        else if (!left_reg && !right_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign merged       = merged_reg;
    assign region_count = count_reg;
    assign stack_top    = stack_reg;

    `RTIM_ASSERT_NOW(a_merge_ok, clk, rst_n, done_reg && merged_reg, status_reg == ST_OK)
    `RTIM_ASSERT_NOW(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(REGION_SLOTS))
    `RTIM_ASSERT_NXT(a_write_done, clk, rst_n, state_reg == WRITE, done_reg && !busy)
    `RTIM_ASSERT_NOW(a_count_match, clk, rst_n, !busy,
                     count_reg == CW'($countones(valid_reg)))
endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the region table insert/merge block.
`timescale 1ns / 1ps
module tb
    import rtim_pkg::*;
;

    localparam int SLOTS = 16;
    localparam logic [47:0] PAGE = 48'h1000;

    // one command transaction as driven on the input ports
    typedef struct {
        logic [1:0]  cmd;
        logic [47:0] s;
        logic [47:0] e;
        logic [47:0] src;
        logic [2:0]  fl;
        logic [1:0]  kind;
    } region_cmd_t;

    // one answer as seen on the result ports
    typedef struct {
        status_t     st;
        logic        mrg;
        logic [4:0]  count;
        logic [47:0] top;
    } answer_t;

    // directed row: typed status/merged where the answer is obvious
    typedef struct {
        region_cmd_t c;
        bit          typed;
        status_t     st;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [47:0] region_start;
    logic [47:0] region_end;
    logic [47:0] source_address;
    logic [2:0]  access_flags;
    logic [1:0]  region_kind;
    logic        done;
    logic [1:0]  status;
    logic        merged;
    logic [4:0]  region_count;
    logic [47:0] stack_top;

    region_table_insert_merge dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .region_start(region_start), .region_end(region_end),
        .source_address(source_address), .access_flags(access_flags),
        .region_kind(region_kind), .done(done), .status(status), .merged(merged),
        .region_count(region_count), .stack_top(stack_top)
    );

    // shadow copy of the region table
    logic [47:0] tbl_start [SLOTS];
    logic [47:0] tbl_end   [SLOTS];
    logic [47:0] tbl_src   [SLOTS];
    logic [2:0]  tbl_fl    [SLOTS];
    logic        tbl_kind  [SLOTS];
    logic        tbl_valid [SLOTS];
    logic [47:0] tbl_stack;

    answer_t pending_answers[$];
    int      errors;
    int      idle_pct;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #30ms;
        $display("tb failed");
        $finish;
    end

    function automatic int live_regions();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i])
                n++;
        return n;
    endfunction

    // Insert with validation, overlap check and coalescing into the shadow table.
    function automatic status_t table_insert(region_cmd_t c, output logic mrg);
        int lft;
        int rgt;
        int free_idx;
        mrg = 1'b0;
        lft = -1;
        rgt = -1;
        free_idx = -1;
        if (c.s[11:0] != 0 || c.e[11:0] != 0 || c.src[11:0] != 0 || !(c.s < c.e) ||
            c.fl == 0 || (c.fl[1] && c.fl[2]) || c.kind > 1)
            return ST_MALFORMED;
        for (int i = 0; i < SLOTS; i++)
            if (tbl_valid[i] && ((tbl_start[i] <= c.s && c.s < tbl_end[i]) ||
                                 (c.s <= tbl_start[i] && tbl_start[i] < c.e)))
                return ST_OVERLAP;
        for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_valid[i]) begin
                if (free_idx < 0)
                    free_idx = i;
                continue;
            end
            if (tbl_kind[i] != c.kind[0] || tbl_fl[i] != c.fl)
                continue;
            // left neighbour: ends at our start, its source runs into ours
            if (tbl_end[i] == c.s &&
                tbl_src[i] + (tbl_end[i] - tbl_start[i]) == c.src)
                lft = i;
            // right neighbour: starts at our end, our source runs into its
            if (tbl_start[i] == c.e && tbl_src[i] == c.src + (c.e - c.s))
                rgt = i;
        end
        if (lft >= 0 && rgt >= 0) begin
            tbl_end[lft] = tbl_end[rgt];
            tbl_valid[rgt] = 1'b0;
            mrg = 1'b1;
        end else if (lft >= 0) begin
            tbl_end[lft] = c.e;
            mrg = 1'b1;
        end else if (rgt >= 0) begin
            tbl_start[rgt] = c.s;
            tbl_src[rgt] = c.src;
            mrg = 1'b1;
        end else begin
            if (free_idx < 0)
                return ST_FULL;
            tbl_start[free_idx] = c.s;
            tbl_end[free_idx] = c.e;
            tbl_src[free_idx] = c.src;
            tbl_fl[free_idx] = c.fl;
            tbl_kind[free_idx] = c.kind[0];
            tbl_valid[free_idx] = 1'b1;
        end
        return ST_OK;
    endfunction

    function automatic answer_t table_apply(region_cmd_t c);
        answer_t a;
        logic m;
        a.st = ST_OK;
        a.mrg = 1'b0;
        if (c.cmd == CMD_CLEAR) begin
            for (int i = 0; i < SLOTS; i++)
                tbl_valid[i] = 1'b0;
        end else if (c.cmd == CMD_INSERT || c.cmd == CMD_STACK) begin
            a.st = table_insert(c, m);
            a.mrg = m;
            if (a.st == ST_OK && c.cmd == CMD_STACK)
                tbl_stack = c.e;
        end else begin
            a.st = ST_MALFORMED; // unused command code
        end
        a.count = 5'(live_regions());
        a.top = tbl_stack;
        return a;
    endfunction

    // Drive one transaction at the falling edge and hold it until accepted.
    task automatic issue(region_cmd_t c, bit typed = 0, status_t st = ST_OK);
        answer_t a;
        @(negedge clk);
        start <= 1'b1;
        command <= c.cmd;
        region_start <= c.s;
        region_end <= c.e;
        source_address <= c.src;
        access_flags <= c.fl;
        region_kind <= c.kind;
        do
            @(posedge clk);
        while (busy);
        a = table_apply(c);
        if (typed) begin
            a.st = st;
            a.mrg = 1'b0;
        end
        pending_answers.push_back(a);
        // random sender gap; start stays high otherwise
        if ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
    endtask

    function automatic region_cmd_t mk(logic [1:0] cmd, logic [47:0] s, logic [47:0] e,
                                       logic [47:0] src, logic [2:0] fl,
                                       logic [1:0] kind);
        region_cmd_t c;
        c.cmd = cmd;
        c.s = s;
        c.e = e;
        c.src = src;
        c.fl = fl;
        c.kind = kind;
        return c;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly well-formed inserts in a small window, often built to touch a stored region.
    function automatic region_cmd_t random_cmd(logic [47:0] base);
        region_cmd_t c;
        logic [47:0] len;
        int r;
        int pick;
        r = $urandom_range(99);
        len = PAGE * $urandom_range(1, 4);
        c.cmd = ($urandom_range(3) == 0) ? CMD_STACK : CMD_INSERT;
        c.fl = 3'($urandom_range(1, 5));
        c.kind = 2'($urandom_range(1));
        if (r < 4) begin
            c = mk(CMD_CLEAR, rand48(), rand48(), rand48(), 3'($urandom), 2'($urandom));
        end else if (r < 14) begin
            // noise: anything the ports allow
            c = mk(2'($urandom), rand48(), rand48(), rand48(), 3'($urandom),
                   2'($urandom));
            if ($urandom_range(1))
                c.s[11:0] = 0;
            if ($urandom_range(1))
                c.e[11:0] = 0;
            if ($urandom_range(1))
                c.src[11:0] = 0;
        end else if (r < 55 && live_regions() > 0) begin
            pick = $urandom_range(SLOTS - 1);
            while (!tbl_valid[pick])
                pick = (pick + 1) % SLOTS;
            c.fl = tbl_fl[pick];
            c.kind = {1'b0, tbl_kind[pick]};
            if ($urandom_range(1)) begin
                c.s = tbl_end[pick];
                c.e = c.s + len;
                c.src = tbl_src[pick] + (tbl_end[pick] - tbl_start[pick]);
            end else begin
                c.e = tbl_start[pick];
                c.s = c.e - len;
                c.src = tbl_src[pick] - len;
            end
            // sometimes break the match
            case ($urandom_range(9))
                0: c.src = c.src + PAGE;
                1: c.fl = 3'($urandom_range(1, 5));
                2: c.kind = ~c.kind & 2'd1;
                default: ;
            endcase
        end else begin
            c.s = base + PAGE * $urandom_range(63);
            c.e = c.s + len;
            c.src = base + PAGE * $urandom_range(127);
        end
        return c;
    endfunction

    // Results are accepted at the rising edge that ends the strobe cycle.
    always @(posedge clk) begin
        answer_t x;
        if (rst_n && done) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected transaction status=%0d merged=%0d count=%0d top=%h",
                         $time, status, merged, region_count, stack_top);
                errors++;
            end else begin
                x = pending_answers.pop_front();
                if (status !== x.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, x.st, status);
                    errors++;
                end
                if (merged !== x.mrg) begin
                    $display("%0t: merged expected %0d actual %0d", $time, x.mrg, merged);
                    errors++;
                end
                if (region_count !== x.count) begin
                    $display("%0t: region_count expected %0d actual %0d",
                             $time, x.count, region_count);
                    errors++;
                end
                if (stack_top !== x.top) begin
                    $display("%0t: stack_top expected %h actual %h", $time, x.top, stack_top);
                    errors++;
                end
            end
        end
    end

    initial begin
        row_t rows[$];
        logic [47:0] base;
        logic [47:0] hi;
        int guard;
        errors = 0;
        idle_pct = 0;
        start = 1'b0;
        command = CMD_INSERT;
        region_start = '0;
        region_end = '0;
        source_address = '0;
        access_flags = '0;
        region_kind = '0;
        tbl_stack = '0;
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        hi = 48'hFFFF_FFFF_F000;
        // directed: a clear and malformed cases first (typed), then the merge shapes
        rows = '{
            '{mk(CMD_CLEAR, 0, 0, 0, 0, 0), 1, ST_OK},
            '{mk(CMD_INSERT, 48'h1001, 48'h3000, 0, 1, 0), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h1000, 48'h3800, 0, 1, 0), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h1000, 48'h3000, 48'hFFF, 1, 0), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h3000, 48'h3000, 0, 1, 0), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h4000, 48'h3000, 0, 1, 0), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h1000, 48'h3000, 0, 0, 0), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h1000, 48'h3000, 0, 6, 0), 1, ST_MALFORMED},
            '{mk(CMD_STACK, 48'h1000, 48'h3000, 0, 7, 1), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h1000, 48'h3000, 0, 1, 2), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h1000, 48'h3000, 0, 1, 3), 1, ST_MALFORMED},
            '{mk(2'd3, 48'h1000, 48'h3000, 0, 1, 0), 1, ST_MALFORMED},
            '{mk(CMD_INSERT, 48'h1_0000, 48'h1_2000, 48'h8_0000, 3, 0), 0, ST_OK},
            '{mk(CMD_INSERT, 48'h1_1000, 48'h1_5000, 48'h9_0000, 3, 0), 0, ST_OK},
            '{mk(CMD_INSERT, 48'h1_2000, 48'h1_3000, 48'h8_2000, 3, 0), 0, ST_OK},
            '{mk(CMD_INSERT, 48'h1_5000, 48'h1_6000, 48'h8_5000, 3, 0), 0, ST_OK},
            '{mk(CMD_INSERT, 48'h1_3000, 48'h1_5000, 48'h8_3000, 3, 0), 0, ST_OK},
            '{mk(CMD_INSERT, 48'h2_1000, 48'h2_2000, 48'h7_0000, 5, 1), 0, ST_OK},
            '{mk(CMD_INSERT, 48'h2_0000, 48'h2_1000, 48'h6_F000, 5, 1), 0, ST_OK},
            '{mk(CMD_STACK, hi, 48'hFFFF_FFFF_F000, hi, 4, 1), 1, ST_MALFORMED},
            '{mk(CMD_STACK, 48'hFFFF_FFFF_E000, hi, hi, 4, 1), 0, ST_OK},
            '{mk(CMD_STACK, 48'hFFFF_FFFF_E000, hi, hi, 4, 1), 0, ST_OK},
            '{mk(CMD_CLEAR, 0, 0, 0, 0, 0), 0, ST_OK}
        };
        foreach (rows[i])
            issue(rows[i].c, rows[i].typed, rows[i].st);
        // fill every slot with isolated regions, then one more for a full table
        for (int i = 0; i <= SLOTS; i++)
            issue(mk(CMD_INSERT, PAGE * (2 * i + 2), PAGE * (2 * i + 3), 0, 1, 1));

        // random phases: back to back, heavy sender gaps, none, light gaps
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 58 : (ph == 3) ? 13 : 0;
            base = rand48();
            base[11:0] = 0;
            for (int n = 0; n < 340; n++)
                issue(random_cmd(base));
        end

        @(negedge clk);
        start <= 1'b0;
        guard = 0;
        while (pending_answers.size() != 0 && guard < 1000) begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_answers.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
